// ===== hw/rtl/ray_box_slab_intersect_assert.svh =====
// assertion macros for the ray box slab block
`ifndef RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`ifndef ASSERT_OFF
`define RBS_ASSERT_IMP(lbl, clk, rstn, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error(msg);
`define RBS_ASSERT_NXT(lbl, clk, rstn, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);
`else
`define RBS_ASSERT_IMP(lbl, clk, rstn, a, b, msg)
`define RBS_ASSERT_NXT(lbl, clk, rstn, a, b, msg)
`endif
`endif

// ===== hw/rtl/rbsi_pkg.sv =====
package rbsi_pkg;
	localparam int COORD_W   = 32;
	localparam int DIR_W     = 19;
	localparam int DIST_W    = 31;
	localparam int FRAC_W    = 17;
	localparam int V_W       = 34;
	localparam int NUM_W     = 33;
	localparam int UD_W      = 33;
	localparam int QW        = NUM_W + 16;
	localparam int T_W       = 42;
	localparam int CFG_IDX_W = 3;

	localparam logic signed [T_W-1:0] T_SAT = {2'b01, 40'd0};
	localparam logic signed [T_W-1:0] T_ONE = {25'd1, 17'd0} >> 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_X,
		CFG_MIN_Y,
		CFG_MIN_Z,
		CFG_MAX_X,
		CFG_MAX_Y,
		CFG_MAX_Z
	} cfg_idx_t;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] start_z;
		logic [DIR_W-1:0]   dir_x;
		logic [DIR_W-1:0]   dir_y;
		logic [DIR_W-1:0]   dir_z;
		logic [DIST_W-1:0]  max_distance;
	} ray_in_t;

	typedef struct packed {
		logic               did_impact;
		logic [FRAC_W-1:0]  fraction;
		logic [COORD_W-1:0] impact_x;
		logic [COORD_W-1:0] impact_y;
		logic [COORD_W-1:0] impact_z;
	} ray_out_t;
endpackage

// ===== hw/rtl/ray_box_slab_intersect.sv =====
// ray versus axis-aligned box, slab method, signed Q16.16
// in channel: in_valid / in_stall with in_data (start point, direction,
// length scale). out channel: out_valid / out_stall with out_data (hit flag,
// entry fraction, impact or end point). one result per ray, in order.
// box corners are written over cfg_we / cfg_index / cfg_data; the user must
// write them only while idle, as the block does not enforce it. one ray enters
// every cycle while the output is not stalled; the restoring divider takes one
// quotient bit per stage over 49 stages, six lanes side by side.
// reset clears the corners to zero and empties the pipeline.
// when the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises; nothing is dropped or repeated.
`include "ray_box_slab_intersect_assert.svh"
module ray_box_slab_intersect (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  rbsi_pkg::ray_in_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output rbsi_pkg::ray_out_t             out_data,
	input  logic                           cfg_we,
	input  logic [rbsi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbsi_pkg::COORD_W-1:0]   cfg_data
);
	import rbsi_pkg::*;

	localparam int DIV_STEPS = QW;

	typedef struct packed {
		logic [UD_W-1:0] r;
		logic [QW-1:0]   n;
		logic [QW-1:0]   q;
		logic [UD_W-1:0] d;
		logic            neg;
	} div_t;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] s;
		logic [2:0][V_W-1:0]     v;
		logic [2:0]              vz;
		logic [2:0]              btw;
	} ctx_t;

	function automatic div_t div_step(div_t x);
		logic [UD_W:0] trial;
		logic [UD_W:0] diff;
		div_t y;
		y = x;
		trial = {x.r, x.n[QW-1]};
		diff = trial - {1'b0, x.d};
		y.n = {x.n[QW-2:0], 1'b0};
		if (trial >= {1'b0, x.d}) begin
			y.r = diff[UD_W-1:0];
			y.q = {x.q[QW-2:0], 1'b1};
		end else begin
			y.r = trial[UD_W-1:0];
			y.q = {x.q[QW-2:0], 1'b0};
		end
		return y;
	endfunction

	logic [2:0][COORD_W-1:0] box_lo_q, box_hi_q;
	logic adv;
	logic out_valid_q;
	ray_out_t out_q;

	assign adv = !out_valid_q || !out_stall;
	assign in_stall = !adv;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_lo_q <= '0;
			box_hi_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_X: box_lo_q[0] <= cfg_data;
				CFG_MIN_Y: box_lo_q[1] <= cfg_data;
				CFG_MIN_Z: box_lo_q[2] <= cfg_data;
				CFG_MAX_X: box_hi_q[0] <= cfg_data;
				CFG_MAX_Y: box_hi_q[1] <= cfg_data;
				CFG_MAX_Z: box_hi_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: displacement and corner offsets
	logic [2:0][COORD_W-1:0] s_in;
	logic [2:0][DIR_W-1:0] d_in;
	logic [2:0][V_W-1:0] v_c;
	logic [2:0][NUM_W-1:0] nlo_c, nhi_c;
	logic signed [DIR_W+DIST_W:0] prod_c [3];

	always_comb begin
		s_in[0] = in_data.start_x;
		s_in[1] = in_data.start_y;
		s_in[2] = in_data.start_z;
		d_in[0] = in_data.dir_x;
		d_in[1] = in_data.dir_y;
		d_in[2] = in_data.dir_z;
		for (int a = 0; a < 3; a++) begin
			prod_c[a] = $signed(d_in[a]) * $signed({1'b0, in_data.max_distance});
			v_c[a] = prod_c[a][V_W+15:16];
			nlo_c[a] = {box_lo_q[a][COORD_W-1], box_lo_q[a]}
				- {s_in[a][COORD_W-1], s_in[a]};
			nhi_c[a] = {box_hi_q[a][COORD_W-1], box_hi_q[a]}
				- {s_in[a][COORD_W-1], s_in[a]};
		end
	end

	logic vld_s1;
	logic [2:0][COORD_W-1:0] s_s1;
	logic [2:0][V_W-1:0] v_s1;
	logic [2:0][NUM_W-1:0] nlo_s1, nhi_s1;

	// stage 2: magnitudes and signs into the divider
	div_t [5:0] div_c;
	ctx_t ctx_c;
	logic [V_W-1:0] vabs_c;
	logic [NUM_W-1:0] ulo_c, uhi_c;

	always_comb begin
		ctx_c.s = s_s1;
		ctx_c.v = v_s1;
		vabs_c = '0;
		ulo_c = '0;
		uhi_c = '0;
		for (int a = 0; a < 3; a++) begin
			ctx_c.vz[a] = (v_s1[a] == '0);
			ctx_c.btw[a] =
				($signed(s_s1[a]) >= $signed(box_lo_q[a]) &&
				 $signed(s_s1[a]) <= $signed(box_hi_q[a])) ||
				($signed(s_s1[a]) >= $signed(box_hi_q[a]) &&
				 $signed(s_s1[a]) <= $signed(box_lo_q[a]));
			vabs_c = v_s1[a][V_W-1] ? (~v_s1[a] + 1'b1) : v_s1[a];
			ulo_c = nlo_s1[a][NUM_W-1] ? (~nlo_s1[a] + 1'b1) : nlo_s1[a];
			uhi_c = nhi_s1[a][NUM_W-1] ? (~nhi_s1[a] + 1'b1) : nhi_s1[a];
			div_c[2*a].r = '0;
			div_c[2*a].q = '0;
			div_c[2*a].n = {ulo_c, 16'd0};
			div_c[2*a].d = ctx_c.vz[a] ? UD_W'(1) : vabs_c[UD_W-1:0];
			div_c[2*a].neg = nlo_s1[a][NUM_W-1] ^ v_s1[a][V_W-1];
			div_c[2*a+1].r = '0;
			div_c[2*a+1].q = '0;
			div_c[2*a+1].n = {uhi_c, 16'd0};
			div_c[2*a+1].d = div_c[2*a].d;
			div_c[2*a+1].neg = nhi_s1[a][NUM_W-1] ^ v_s1[a][V_W-1];
		end
	end

	logic [DIV_STEPS:0] dvld_sx;
	div_t [5:0] div_sx [DIV_STEPS+1];
	ctx_t ctx_sx [DIV_STEPS+1];

	// stage 3: signed, saturated slab bounds
	logic [5:0][T_W-1:0] t_c;
	logic [T_W-1:0] mag_c;
	div_t dl_c;

	always_comb begin
		mag_c = '0;
		dl_c = '0;
		for (int l = 0; l < 6; l++) begin
			dl_c = div_sx[DIV_STEPS][l];
			if (|dl_c.q[QW-1:T_W-2]) begin
				mag_c = T_SAT;
			end else begin
				mag_c = {1'b0, dl_c.q[T_W-2:0]} + T_W'(dl_c.neg && (dl_c.r != '0));
			end
			t_c[l] = dl_c.neg ? (~mag_c + 1'b1) : mag_c;
		end
	end

	logic vld_s3;
	logic [5:0][T_W-1:0] t_s3;
	ctx_t ctx_s3;

	// stage 4: overlap of the three slabs
	logic signed [T_W-1:0] t1_c, t2_c, tl_c, th_c, lo_c, hi_c;
	logic hit_c;

	always_comb begin
		lo_c = {1'b1, {(T_W-1){1'b0}}};
		hi_c = {1'b0, {(T_W-1){1'b1}}};
		t1_c = '0;
		t2_c = '0;
		tl_c = '0;
		th_c = '0;
		for (int a = 0; a < 3; a++) begin
			if (!ctx_s3.vz[a]) begin
				t1_c = $signed(t_s3[2*a]);
				t2_c = $signed(t_s3[2*a+1]);
				tl_c = (t1_c < t2_c) ? t1_c : t2_c;
				th_c = (t1_c < t2_c) ? t2_c : t1_c;
				if (tl_c > lo_c) lo_c = tl_c;
				if (th_c < hi_c) hi_c = th_c;
			end
		end
		// all axes without displacement leave no bounded entry
		hit_c = !(|(ctx_s3.vz & ~ctx_s3.btw)) && !(&ctx_s3.vz) && (lo_c <= hi_c)
			&& (lo_c >= 0) && (lo_c <= T_ONE);
	end

	logic vld_s4, hit_s4;
	logic [FRAC_W-1:0] frac_s4;
	ctx_t ctx_s4;

	// stage 5: offset along the ray; a miss uses fraction one, which gives v
	logic signed [V_W+FRAC_W:0] off_c [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			off_c[a] = $signed(ctx_s4.v[a]) * $signed({1'b0, frac_s4});
		end
	end

	logic vld_s5, hit_s5;
	logic [FRAC_W-1:0] frac_s5;
	logic [2:0][COORD_W-1:0] s_s5;
	logic [2:0][V_W-1:0] off_s5;

	// stage 6: final point, saturated
	logic signed [V_W:0] sum_c [3];
	logic [2:0][COORD_W-1:0] pt_c;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sum_c[a] = $signed({{(V_W+1-COORD_W){s_s5[a][COORD_W-1]}}, s_s5[a]})
				+ $signed({off_s5[a][V_W-1], off_s5[a]});
			if (sum_c[a] > $signed({{(V_W+1-COORD_W){1'b0}}, 1'b0, {(COORD_W-1){1'b1}}}))
				pt_c[a] = {1'b0, {(COORD_W-1){1'b1}}};
			else if (sum_c[a] < $signed({{(V_W+1-COORD_W){1'b1}}, 1'b1, {(COORD_W-1){1'b0}}}))
				pt_c[a] = {1'b1, {(COORD_W-1){1'b0}}};
			else
				pt_c[a] = sum_c[a][COORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			dvld_sx <= '0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			dvld_sx <= {dvld_sx[DIV_STEPS-1:0], vld_s1};
			vld_s3 <= dvld_sx[DIV_STEPS];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			out_valid_q <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s1 <= s_in;
			v_s1 <= v_c;
			nlo_s1 <= nlo_c;
			nhi_s1 <= nhi_c;
			div_sx[0] <= div_c;
			ctx_sx[0] <= ctx_c;
			for (int k = 0; k < DIV_STEPS; k++) begin
				ctx_sx[k+1] <= ctx_sx[k];
				for (int l = 0; l < 6; l++) begin
					div_sx[k+1][l] <= div_step(div_sx[k][l]);
				end
			end
			t_s3 <= t_c;
			ctx_s3 <= ctx_sx[DIV_STEPS];
			hit_s4 <= hit_c;
			frac_s4 <= hit_c ? lo_c[FRAC_W-1:0] : T_ONE[FRAC_W-1:0];
			ctx_s4 <= ctx_s3;
			hit_s5 <= hit_s4;
			frac_s5 <= frac_s4;
			s_s5 <= ctx_s4.s;
			for (int a = 0; a < 3; a++) begin
				off_s5[a] <= off_c[a][V_W+15:16];
			end
			out_q.did_impact <= hit_s5;
			out_q.fraction <= frac_s5;
			out_q.impact_x <= pt_c[0];
			out_q.impact_y <= pt_c[1];
			out_q.impact_z <= pt_c[2];
		end
	end

	`RBS_ASSERT_IMP(a_miss_frac, clk, arst_n, out_valid_q && !out_q.did_impact, out_q.fraction == T_ONE[FRAC_W-1:0], "miss without fraction one")
	`RBS_ASSERT_IMP(a_hit_frac, clk, arst_n, out_valid_q && out_q.did_impact, out_q.fraction <= T_ONE[FRAC_W-1:0], "hit fraction above one")
	`RBS_ASSERT_NXT(a_stall_hold, clk, arst_n, !adv, $stable(dvld_sx) && $stable(vld_s5), "pipeline moved while stalled")
	`RBS_ASSERT_NXT(a_advance, clk, arst_n, adv && vld_s5, out_valid_q, "result lost at output")
endmodule
